/* rtl/npe_pkg.sv */
// Shared types, constants and saturating helpers for the normalized polynomial evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package npe_pkg;

  // Fixed-point format and pipeline depth
  localparam int MAX_ORDER     = 4;
  localparam int FRAC_BITS     = 16;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ORDER_W       = 3;
  localparam int ORD_W         = $clog2(MAX_ORDER + 1);
  localparam int NUM_COEF_REGS = 5;
  localparam int NUM_REGS      = 3 + NUM_COEF_REGS;
  localparam int CFG_IDX_W     = $clog2(NUM_REGS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = CFG_IDX_W'(2);
  localparam int                   REG_COEF0     = 3;

  localparam logic signed [DATA_W-1:0] ONE_FX  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] ROUND_P = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Saturated value with its overflow mark
  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // One word in flight between the pipeline sections
  typedef struct packed {
    logic                     valid;
    logic                     ovf;
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] p;
    logic signed [DATA_W-1:0] acc;
  } pipe_t;

  // Clamp a one-bit-wider sum to the data range
  function automatic sat_t sat_wide(input logic signed [DATA_W:0] v);
    sat_t r;
    r.ovf = v[DATA_W] ^ v[DATA_W-1];
    if (r.ovf) begin
      r.val = v[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Drop the fraction bits of a rounded product (floor shift) and clamp
  function automatic sat_t round_sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0]     sh;
    logic        [PROD_W-DATA_W:0] top;
    sat_t                          r;
    sh    = v >>> FRAC_BITS;
    top   = sh[PROD_W-1:DATA_W-1];
    r.ovf = !((&top) || (~|top));
    if (r.ovf) begin
      r.val = sh[PROD_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = sh[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/npe_front.sv */
// Front section: offset removal, scaling multiply and rounding to the normalized argument.
// Depends on npe_pkg.
`timescale 1ns / 1ps

module npe_front
  import npe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] position,
  input  logic signed [DATA_W-1:0] center,
  input  logic signed [DATA_W-1:0] inv_scale,
  input  logic signed [DATA_W-1:0] coef0,
  output pipe_t                    pipe_o
);

  logic                     v0_r, v1_r, v2_r;
  logic signed [DATA_W-1:0] d_r;
  logic                     ovf0_r, ovf1_r, ovf2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] u_r;
  sat_t                     d_sat;
  sat_t                     u_sat;

  // offset removal, saturated
  always_comb begin
    d_sat = sat_wide((DATA_W + 1)'(position) - (DATA_W + 1)'(center));
  end

  assign u_sat = round_sat(prod_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // payload stages: difference, product, normalized argument
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_sat.val;
      ovf0_r <= d_sat.ovf;
      prod_r <= PROD_W'(d_r) * PROD_W'(inv_scale) + ROUND_P;
      ovf1_r <= ovf0_r;
      u_r    <= u_sat.val;
      ovf2_r <= ovf1_r | u_sat.ovf;
    end
  end

  // power 1 equals u exactly and term 0 equals coef0 exactly
  assign pipe_o.valid = v2_r;
  assign pipe_o.ovf   = ovf2_r;
  assign pipe_o.u     = u_r;
  assign pipe_o.p     = u_r;
  assign pipe_o.acc   = coef0;

endmodule

/* rtl/npe_step.sv */
// One power step: term product and next power in a multiply stage, then round and accumulate.
// Depends on npe_pkg.
`timescale 1ns / 1ps

module npe_step
  import npe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     term_en,
  input  logic                     pwr_en,
  input  logic signed [DATA_W-1:0] coef,
  input  pipe_t                    pipe_i,
  output pipe_t                    pipe_o
);

  logic                     va_r, vb_r;
  logic                     ovfa_r, ovfb_r;
  logic signed [DATA_W-1:0] ua_r, ub_r;
  logic signed [DATA_W-1:0] acca_r, accb_r;
  logic signed [PROD_W-1:0] term_prod_r, pwr_prod_r;
  logic signed [DATA_W-1:0] pb_r;
  sat_t                     term_sat, pwr_sat, acc_sat;
  logic                     ovf_nxt;

  // round the products and add the term
  always_comb begin
    term_sat = round_sat(term_prod_r);
    pwr_sat  = round_sat(pwr_prod_r);
    acc_sat  = sat_wide((DATA_W + 1)'(acca_r) + (DATA_W + 1)'(term_sat.val));
    ovf_nxt  = ovfa_r | (term_en & (term_sat.ovf | acc_sat.ovf)) | (pwr_en & pwr_sat.ovf);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= pipe_i.valid;
      vb_r <= va_r;
    end
  end

  // multiply stage, then round/accumulate stage
  always_ff @(posedge clk) begin
    if (en) begin
      term_prod_r <= PROD_W'(pipe_i.p) * PROD_W'(coef) + ROUND_P;
      pwr_prod_r  <= PROD_W'(pipe_i.p) * PROD_W'(pipe_i.u) + ROUND_P;
      ovfa_r      <= pipe_i.ovf;
      ua_r        <= pipe_i.u;
      acca_r      <= pipe_i.acc;
      ovfb_r      <= ovf_nxt;
      ub_r        <= ua_r;
      pb_r        <= pwr_sat.val;
      accb_r      <= term_en ? acc_sat.val : acca_r;
    end
  end

  assign pipe_o.valid = vb_r;
  assign pipe_o.ovf   = ovfb_r;
  assign pipe_o.u     = ub_r;
  assign pipe_o.p     = pb_r;
  assign pipe_o.acc   = accb_r;

endmodule

/* rtl/npe_skid.sv */
// Output register with a skid stage; holds the pipeline when both are full.
// Depends on npe_pkg.
`timescale 1ns / 1ps

module npe_skid
  import npe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_t                    pipe_i,
  output logic                     en,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_ovf
);

  logic                     out_valid_r, out_valid_nxt;
  logic                     skid_valid_r, skid_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt, skid_value_r;
  logic                     out_ovf_r, out_ovf_nxt, skid_ovf_r;
  logic                     load_skid;

  assign en = !skid_valid_r;

  // next state of the two slots
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_ovf_nxt    = out_ovf_r;
    skid_valid_nxt = skid_valid_r;
    load_skid      = 1'b0;
    if (out_valid_r && !out_ready) begin
      if (en && pipe_i.valid) begin
        skid_valid_nxt = 1'b1;
        load_skid      = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = skid_value_r;
      out_ovf_nxt    = skid_ovf_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = pipe_i.valid;
      out_value_nxt = pipe_i.acc;
      out_ovf_nxt   = pipe_i.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (load_skid) begin
      skid_value_r <= pipe_i.acc;
      skid_ovf_r   <= pipe_i.ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_ovf   = out_ovf_r;

endmodule

/* rtl/normalized_polynomial_eval.sv */
// Normalized polynomial evaluator: top level with configuration registers.
// Depends on npe_pkg, npe_front, npe_step and npe_skid.
//
// Use: each word on the in_ stream carries one Q16.16 position x. The block
// returns sum of coef_i * ((x - center) * inv_scale)^i, i = 0..min(poly_order, MAX_ORDER),
// all steps rounded and saturated to 32 bits; out_tuser flags any saturation.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while no word is in flight, as the block itself does not enforce it.
// Register map: 0 poly_order, 1 center, 2 inv_scale, 3..7 coef_0..coef_4.
// Pipeline: the front section, then the power steps, one multiply stage and
// one round/accumulate stage each, then the output register with its skid slot.
// Throughput: one word per cycle, sustained while the receiver keeps up.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: order 0, center 0, inv_scale 1.0, all coefficients 0.
// When the receiver stalls, one finished word waits in the output register
// and one more in a skid slot; only then does in_tready fall and the whole
// pipeline hold. Nothing is dropped or repeated.
`timescale 1ns / 1ps

module normalized_polynomial_eval
  import npe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] position
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [31:0] value
  output logic [0:0]           out_tuser,  // [0] overflow
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  logic        [ORDER_W-1:0] poly_order_r;
  logic signed [DATA_W-1:0]  center_r;
  logic signed [DATA_W-1:0]  inv_scale_r;
  logic signed [DATA_W-1:0]  coef_r [0:MAX_ORDER];
  logic        [ORD_W-1:0]   ord_eff;
  logic                      en;
  pipe_t                     chain [0:MAX_ORDER];
  logic signed [DATA_W-1:0]  value_w;
  logic                      ovf_w;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_order_r <= '0;
      center_r     <= '0;
      inv_scale_r  <= ONE_FX;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_ORDER) begin
        poly_order_r <= cfg_wdata[ORDER_W-1:0];
      end
      if (cfg_index == REG_CENTER) begin
        center_r <= cfg_wdata;
      end
      if (cfg_index == REG_INV_SCALE) begin
        inv_scale_r <= cfg_wdata;
      end
      for (int k = 0; k <= MAX_ORDER; k++) begin
        if (k < NUM_COEF_REGS && cfg_index == CFG_IDX_W'(REG_COEF0 + k)) begin
          coef_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // order codes above the top power act as the top power
  always_comb begin
    if (32'(poly_order_r) > 32'(MAX_ORDER)) begin
      ord_eff = ORD_W'(MAX_ORDER);
    end else begin
      ord_eff = ORD_W'(poly_order_r);
    end
  end

  npe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .position  (in_tdata),
    .center    (center_r),
    .inv_scale (inv_scale_r),
    .coef0     (coef_r[0]),
    .pipe_o    (chain[0])
  );

  // one step per power 1..MAX_ORDER
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_step
    npe_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .term_en (ord_eff >= ORD_W'(k + 1)),
      .pwr_en  (ord_eff > ORD_W'(k + 1)),
      .coef    (coef_r[k+1]),
      .pipe_i  (chain[k]),
      .pipe_o  (chain[k+1])
    );
  end

  npe_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_i    (chain[MAX_ORDER]),
    .en        (en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (value_w),
    .out_ovf   (ovf_w)
  );

  assign in_tready    = en;
  assign out_tdata    = value_w;
  assign out_tuser[0] = ovf_w;

endmodule

/* dv/poly_value_check.sv */
// Result checker for the normalized polynomial evaluator: follows the register
// writes, predicts each accepted word and compares it with the result stream.
// Depends on npe_pkg for widths, register indexes and the fixed-point format.
`timescale 1ns / 1ps

module poly_value_check
  import npe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] position
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [DATA_W-1:0]    out_tdata,  // [31:0] value
  input  logic [0:0]           out_tuser,  // [0] overflow
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   pending_words,
  output int                   results_checked,
  output int                   overflow_seen
);

  localparam longint HALF_LSB   = longint'(1) << (FRAC_BITS - 1);
  localparam longint UNITY      = longint'(1) << FRAC_BITS;
  localparam longint FX_MAX     = 64'sd2147483647;
  localparam longint FX_MIN     = -64'sd2147483648;
  localparam int     REPORT_CAP = 100;

  // Shadow copy of the register file
  logic [ORDER_W-1:0] order_r;
  longint             center_r;
  longint             scale_r;
  longint             coef_r [0:MAX_ORDER];

  // Expected results, oldest first
  logic [DATA_W-1:0]  value_q [$];
  logic               ovf_q [$];

  initial begin
    fail_count      = 0;
    pending_words   = 0;
    results_checked = 0;
    overflow_seen   = 0;
  end

  // Clamp to the signed 32-bit range, marking any saturation
  function automatic longint clamp32(input longint v, inout bit ovf);
    if (v > FX_MAX) begin
      ovf = 1'b1;
      return FX_MAX;
    end
    if (v < FX_MIN) begin
      ovf = 1'b1;
      return FX_MIN;
    end
    return v;
  endfunction

  // Rounded fixed-point product: add half an LSB, floor shift, clamp
  function automatic longint fx_mul(input longint a, input longint b, inout bit ovf);
    return clamp32((a * b + HALF_LSB) >>> FRAC_BITS, ovf);
  endfunction

  // Polynomial in the normalized argument, every step saturated
  function automatic void eval_poly(input  logic [DATA_W-1:0] pos,
                                    output logic [DATA_W-1:0] value,
                                    output logic              ovf_o);
    bit     ovf;
    longint d;
    longint u;
    longint p;
    longint acc;
    longint term;
    int     ord;
    ovf = 1'b0;
    d   = clamp32(longint'($signed(pos)) - center_r, ovf);
    u   = fx_mul(d, scale_r, ovf);
    p   = UNITY;
    acc = 0;
    // order codes past the top power behave as the top power
    ord = (int'(order_r) > MAX_ORDER) ? MAX_ORDER : int'(order_r);
    for (int i = 0; i <= ord; i++) begin
      term = fx_mul(p, coef_r[i], ovf);
      acc  = clamp32(acc + term, ovf);
      // the power after the last term is never formed
      if (i < ord) p = fx_mul(p, u, ovf);
    end
    value = acc[DATA_W-1:0];
    ovf_o = ovf;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] exp_value;
    logic              exp_ovf;
    if (!rst_n) begin
      order_r  = '0;
      center_r = 0;
      scale_r  = UNITY;
      for (int k = 0; k <= MAX_ORDER; k++) coef_r[k] = 0;
      value_q.delete();
      ovf_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ORDER:     order_r  = cfg_wdata[ORDER_W-1:0];
          REG_CENTER:    center_r = longint'($signed(cfg_wdata));
          REG_INV_SCALE: scale_r  = longint'($signed(cfg_wdata));
          default: begin
            if (int'(cfg_index) >= REG_COEF0 && int'(cfg_index) - REG_COEF0 <= MAX_ORDER)
              coef_r[int'(cfg_index) - REG_COEF0] = longint'($signed(cfg_wdata));
          end
        endcase
      end

      // result word against the oldest expectation
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (out_tuser[0]) overflow_seen++;
        if (value_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: result word value %h overflow %b with nothing expected",
                     $time, out_tdata, out_tuser[0]);
        end else begin
          exp_value = value_q.pop_front();
          exp_ovf   = ovf_q.pop_front();
          if (out_tdata !== exp_value) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $display("%0t: value mismatch, expected %h actual %h",
                       $time, exp_value, out_tdata);
          end
          if (out_tuser[0] !== exp_ovf) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $display("%0t: overflow mismatch, expected %b actual %b",
                       $time, exp_ovf, out_tuser[0]);
          end
        end
      end

      // accepted input word
      if (in_tvalid && in_tready) begin
        eval_poly(in_tdata, exp_value, exp_ovf);
        value_q.push_back(exp_value);
        ovf_q.push_back(exp_ovf);
      end
    end
    pending_words <= value_q.size();
  end

endmodule

/* dv/tb_normalized_polynomial_eval.sv */
// Testbench top for the normalized polynomial evaluator: clock, reset, register
// settings, position stimulus and receiver back-pressure; gives the verdict.
// Depends on npe_pkg, normalized_polynomial_eval and poly_value_check.
`timescale 1ns / 1ps

module tb_normalized_polynomial_eval;
  import npe_pkg::*;

  localparam int LATENCY       = 3 + 2 * MAX_ORDER;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_SETS   = 32;
  localparam int WORDS_PER_SET = 36;
  localparam int CALM_SETS     = 3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_W-1:0]    out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  int fail_count;
  int pending_words;
  int results_checked;
  int overflow_seen;

  // Stimulus control; calm, hold_req and hold_done are shared with the receiver process
  bit calm;
  bit hold_req;
  bit hold_done;
  int gap_odds;
  int words_sent;
  int settings_run;
  int cycle_count;

  // Setting to be loaded next
  logic [ORDER_W-1:0] cur_order;
  logic [DATA_W-1:0]  cur_center;
  logic [DATA_W-1:0]  cur_scale;
  logic [DATA_W-1:0]  cur_coef [0:MAX_ORDER];

  normalized_polynomial_eval dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  poly_value_check value_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_words   (pending_words),
    .results_checked (results_checked),
    .overflow_seen   (overflow_seen)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_words);
    $display("tb_normalized_polynomial_eval failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    out_tready = 1'b0;
    mode       = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!calm && mode != 0 && $urandom_range(0, mode == 1 ? 3 : 15) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Signed value of up to 2^spread in magnitude; spread 31 is the full range
  function automatic logic [DATA_W-1:0] near(input int spread);
    logic signed [DATA_W-1:0] r;
    r = $urandom;
    return r >>> (31 - spread);
  endfunction

  // Mostly moderate values, with the extremes and zero mixed in
  function automatic logic [DATA_W-1:0] rand_fx(input int spread);
    case ($urandom_range(0, 9))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return '0;
      3:       return near(31);
      default: return near(spread);
    endcase
  endfunction

  // Offer one position word and hold it until accepted
  task automatic send_word(input logic [DATA_W-1:0] pos);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Stop offering, wait until every result is back and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write the whole register file from the cur_ setting
  task automatic load_setting();
    settle();
    write_reg(REG_ORDER, DATA_W'(cur_order));
    write_reg(REG_CENTER, cur_center);
    write_reg(REG_INV_SCALE, cur_scale);
    for (int k = 0; k <= MAX_ORDER; k++)
      write_reg(CFG_IDX_W'(REG_COEF0 + k), cur_coef[k]);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    gap_odds     = 4;
    words_sent   = 0;
    settings_run = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: order 0 with a zero constant term
    send_word(SAT_MAX);
    send_word(SAT_MIN);

    // full order with distinct coefficients at unit scale
    cur_order  = 3'd4;
    cur_center = '0;
    cur_scale  = ONE_FX;
    cur_coef[0] = 32'h0001_0000;
    cur_coef[1] = 32'h0002_0000;
    cur_coef[2] = 32'hffff_8000;
    cur_coef[3] = 32'h0000_4000;
    cur_coef[4] = 32'hffff_0000;
    load_setting();
    send_word(32'h0000_0000);
    send_word(32'h0001_0000);
    send_word(32'hffff_0000);
    send_word(32'h0000_8000);
    send_word(32'h0000_0001);
    send_word(SAT_MAX);
    send_word(SAT_MIN);

    // scale and coefficients at their top, center at its bottom, order code past the top power
    cur_order  = 3'd7;
    cur_center = SAT_MIN;
    cur_scale  = SAT_MAX;
    for (int k = 0; k <= MAX_ORDER; k++) cur_coef[k] = SAT_MAX;
    load_setting();
    send_word(SAT_MAX);
    send_word(SAT_MIN);

    // scale and coefficients at their bottom, center at its top
    cur_order  = 3'd5;
    cur_center = SAT_MAX;
    cur_scale  = SAT_MIN;
    for (int k = 0; k <= MAX_ORDER; k++) cur_coef[k] = SAT_MIN;
    load_setting();
    send_word(SAT_MIN);
    send_word(SAT_MAX);

    // zero scale: the constant term comes straight through
    cur_order   = 3'd6;
    cur_center  = 32'h0001_2345;
    cur_scale   = '0;
    cur_coef[0] = 32'h0003_0000;
    for (int k = 1; k <= MAX_ORDER; k++) cur_coef[k] = SAT_MAX;
    load_setting();
    send_word($urandom);
    send_word(SAT_MAX);
    send_word(SAT_MIN);

    // huge normalized argument at order 1: the square is never formed
    cur_order   = 3'd1;
    cur_center  = '0;
    cur_scale   = SAT_MAX;
    cur_coef[0] = '0;
    cur_coef[1] = 32'h0000_0001;
    for (int k = 2; k <= MAX_ORDER; k++) cur_coef[k] = SAT_MAX;
    load_setting();
    send_word(32'h0001_0000);
    send_word(32'hffff_0000);

    // half scale: rounding ties go toward plus infinity
    cur_order   = 3'd1;
    cur_scale   = 32'h0000_8000;
    cur_coef[1] = ONE_FX;
    load_setting();
    send_word(32'h0000_0001);
    send_word(32'hffff_ffff);
    send_word(32'h0000_0003);
    send_word(32'hffff_fffd);

    // random settings; the first one carries the long receiver hold-off
    for (int s = 0; s < RANDOM_SETS; s++) begin
      cur_order  = ORDER_W'($urandom_range(0, 7));
      cur_center = rand_fx(24);
      cur_scale  = rand_fx(17);
      for (int k = 0; k <= MAX_ORDER; k++) cur_coef[k] = rand_fx(18);
      load_setting();
      if (s == 0) hold_req = 1'b1;
      if (s >= RANDOM_SETS - CALM_SETS) calm = 1'b1;
      gap_odds = $urandom_range(0, 2) * 4;
      for (int w = 0; w < WORDS_PER_SET; w++) begin
        if ($urandom_range(0, 3) == 0) send_word(rand_fx(31));
        else send_word(cur_center + near(17));
      end
    end

    settle();
    $display("Covered %0d words over %0d register settings, orders 0 to 7, zero and extreme scales",
             words_sent, settings_run);
    $display("Checked %0d results, %0d of them saturated", results_checked, overflow_seen);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_normalized_polynomial_eval passed");
    end else begin
      $display("tb_normalized_polynomial_eval failed");
    end
    $finish;
  end

endmodule
